// ===== design/scerr_pkg.sv =====
package scerr_pkg;

  // default table depth
  localparam int ENTRIES_DEF = 8;

  localparam logic       CMD_RECORD = 1'b0;
  localparam logic       CMD_CLEAR  = 1'b1;

  localparam logic [3:0] CODE_NONE  = 4'd0;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  file_id;
    logic [31:0] chunk_key;
    logic [3:0]  err_kind;
    logic [31:0] failed_segment;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        error_pending;
    logic [7:0]  current_file;
    logic [31:0] current_chunk;
    logic [3:0]  current_code;
    logic [31:0] current_segment;
  } rsp_t;

  // one stored record
  typedef struct packed {
    logic [7:0]  file;
    logic [31:0] chunk;
    logic [3:0]  code;
    logic [31:0] segment;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== design/scerr_ctrl.sv =====
module scerr_ctrl import scerr_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  dp_sts_t                              sts,
  output ctl_cmd_t                             cmd,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_idx
);

  localparam int IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  assign rd_idx = idx_r;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = sts.skip ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ===== design/scerr_dp.sv =====
module scerr_dp import scerr_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  req_t                                 in_data,
  input  ctl_cmd_t                             cmd,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_idx,
  output dp_sts_t                              sts,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rsp_t                                 out_data
);

  localparam int IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

  // record storage, valid bits kept in flops
  entry_t           mem [ENTRIES];
  entry_t           rd_data_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt;

  req_t             req_r;

  // compare stage
  logic             cmp_en_r;
  logic [IDX_W-1:0] cmp_idx_r;

  // scan results
  logic             match_fnd_r, free_fnd_r, repl_fnd_r;
  logic [IDX_W-1:0] match_idx_r, free_idx_r;
  entry_t           repl_r;

  // current error
  logic             pending_r, pending_nxt;
  logic             ident_r, ident_nxt;
  logic [7:0]       cur_file_r, cur_file_nxt;
  logic [31:0]      cur_chunk_r, cur_chunk_nxt;
  logic [3:0]       cur_code_r, cur_code_nxt;
  logic [31:0]      cur_seg_r, cur_seg_nxt;

  logic             out_valid_r;
  rsp_t             out_data_r;

  logic             cmp_v, cmp_hit;
  logic             mem_we;
  logic [IDX_W-1:0] slot;
  logic [1:0]       status;

  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.skip     = (in_data.cmd == CMD_RECORD) ?
                        (in_data.err_kind == CODE_NONE || (pending_r && !ident_r)) :
                        !ident_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cmp_v   = valid_r[cmp_idx_r];
  assign cmp_hit = cmp_v && rd_data_r.file == req_r.file_id
                         && rd_data_r.chunk == req_r.chunk_key;

  assign slot = match_fnd_r ? match_idx_r : free_idx_r;

  // commit: apply the request to the table and the current error
  always_comb begin
    valid_nxt     = valid_r;
    pending_nxt   = pending_r;
    ident_nxt     = ident_r;
    cur_file_nxt  = cur_file_r;
    cur_chunk_nxt = cur_chunk_r;
    cur_code_nxt  = cur_code_r;
    cur_seg_nxt   = cur_seg_r;
    mem_we        = 1'b0;
    status        = ST_DONE;
    if (req_r.cmd == CMD_RECORD) begin
      if (req_r.err_kind == CODE_NONE || (pending_r && !ident_r)) begin
        status = ST_REFUSED;
      end else if (!match_fnd_r && !free_fnd_r) begin
        status = ST_FULL;
      end else begin
        mem_we          = 1'b1;
        valid_nxt[slot] = 1'b1;
        pending_nxt     = 1'b1;
        ident_nxt       = 1'b1;
        cur_file_nxt    = req_r.file_id;
        cur_chunk_nxt   = req_r.chunk_key;
        cur_code_nxt    = req_r.err_kind;
        cur_seg_nxt     = req_r.failed_segment;
      end
    end else begin
      if (!ident_r) begin
        status = ST_IGNORED;
      end else begin
        if (match_fnd_r) valid_nxt[match_idx_r] = 1'b0;
        if (repl_fnd_r) begin
          pending_nxt   = 1'b1;
          cur_file_nxt  = repl_r.file;
          cur_chunk_nxt = repl_r.chunk;
          cur_code_nxt  = repl_r.code;
          cur_seg_nxt   = repl_r.segment;
        end else begin
          pending_nxt  = 1'b0;
          ident_nxt    = 1'b0;
          cur_code_nxt = CODE_NONE;
          cur_seg_nxt  = '1;
        end
      end
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit && mem_we) begin
      mem[slot] <= '{file: req_r.file_id, chunk: req_r.chunk_key,
                     code: req_r.err_kind, segment: req_r.failed_segment};
    end
    rd_data_r <= mem[rd_idx];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
    cmp_idx_r <= rd_idx;
    if (cmd.load) begin
      match_idx_r <= '0;
      free_idx_r  <= '0;
    end else if (cmp_en_r) begin
      if (cmp_hit && !match_fnd_r) match_idx_r <= cmp_idx_r;
      if (!cmp_v && !free_fnd_r) free_idx_r <= cmp_idx_r;
      if (cmp_v && !cmp_hit && !repl_fnd_r) repl_r <= rd_data_r;
    end
    if (cmd.commit) begin
      out_data_r <= '{status: status, error_pending: pending_nxt,
                      current_file: cur_file_nxt, current_chunk: cur_chunk_nxt,
                      current_code: cur_code_nxt, current_segment: cur_seg_nxt};
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cmp_en_r    <= 1'b0;
      match_fnd_r <= 1'b0;
      free_fnd_r  <= 1'b0;
      repl_fnd_r  <= 1'b0;
      pending_r   <= 1'b0;
      ident_r     <= 1'b0;
      cur_file_r  <= '0;
      cur_chunk_r <= '0;
      cur_code_r  <= CODE_NONE;
      cur_seg_r   <= '1;
      out_valid_r <= 1'b0;
    end else begin
      cmp_en_r <= cmd.scan;
      if (cmd.load) begin
        match_fnd_r <= 1'b0;
        free_fnd_r  <= 1'b0;
        repl_fnd_r  <= 1'b0;
      end else if (cmp_en_r) begin
        if (cmp_hit) match_fnd_r <= 1'b1;
        if (!cmp_v) free_fnd_r <= 1'b1;
        if (cmp_v && !cmp_hit) repl_fnd_r <= 1'b1;
      end
      if (cmd.commit) begin
        valid_r     <= valid_nxt;
        pending_r   <= pending_nxt;
        ident_r     <= ident_nxt;
        cur_file_r  <= cur_file_nxt;
        cur_chunk_r <= cur_chunk_nxt;
        cur_code_r  <= cur_code_nxt;
        cur_seg_r   <= cur_seg_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== design/scoped_error_table_top.sv =====
// Channel  Dir  Handshake            Payload
// in_      in   in_valid/in_ready    in_data  (req_t: cmd, key, code, segment)
// out_     out  out_valid/out_ready  out_data (rsp_t: status, current error)
//
// Scanned request: one table entry read per cycle, then drain and commit; the result
// is registered at commit, and the next request is accepted once back in idle.
// Refused records and ignored clears skip the scan and go straight to commit.
// A record into a full table is known only after the full scan.
// Synchronous active-low reset clears the valid bits and the current error.
// A new request is taken while a result waits; its commit stalls until it drains.
module scoped_error_table_top import scerr_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  localparam int IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

  ctl_cmd_t         cmd;    // load / scan / commit strobes
  dp_sts_t          sts;    // early-out and output-slot status
  logic [IDX_W-1:0] rd_idx; // table entry being read

  // sequencer: accept, per-entry scan, commit
  scerr_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .rd_idx   (rd_idx)
  );

  // table memory, key compare, current-error registers, output register
  scerr_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .rd_idx    (rd_idx),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
